/* rtl/mvt_pkg.sv */
// ============================================================================
// mvt_pkg
// Shared types, constants and fp32 helpers for the 4x4 matrix-vector core.
// ============================================================================
package mvt_pkg;

    localparam int unsigned NumRegs   = 8;
    localparam int unsigned RegIdxW   = 3;
    localparam int unsigned CfgAddrW  = 4;
    localparam logic [31:0] QnanBits  = 32'h7FC0_0000;
    localparam logic [31:0] InfBits   = 32'h7F80_0000;

    localparam logic [63:0] ResetVals [NumRegs] = '{
        64'h0000_0000_3F80_0000, 64'h0,
        64'h3F80_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_3F80_0000,
        64'h0,                   64'h3F80_0000_0000_0000
    };

    // special-case class of an unpacked operand
    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
    } fcls_t;

    function automatic fcls_t fclass(input logic [31:0] x);
        fcls_t c;
        c.nan  = (x[30:0] > InfBits[30:0]);
        c.inf  = (x[30:0] == InfBits[30:0]);
        c.zero = (x[30:0] == 31'd0);
        return c;
    endfunction

    // leading-zero count over 64 bits
    function automatic logic [6:0] lzc64(input logic [63:0] m);
        logic [6:0] n;
        logic       done;
        n    = 7'd64;
        done = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!done && m[i]) begin
                n    = 7'(63 - i);
                done = 1'b1;
            end
        end
        return n;
    endfunction

    // round normalized m (bit 62 set) * 2^e to fp32, nearest-even
    function automatic logic [31:0] fround(input logic s, input logic signed [11:0] e,
                                           input logic [63:0] m);
        logic signed [11:0] bexp;
        logic [6:0]         sh;
        logic [63:0]        q;
        logic [63:0]        rem;
        logic [63:0]        half;
        logic [63:0]        msk;
        logic [31:0]        r;
        bexp = e + 12'sd189;
        if (bexp >= 12'sd1) sh = 7'd39;
        else if (bexp < -12'sd23) sh = 7'd64;
        else sh = 7'(12'sd40 - bexp);
        r = '0;
        if (sh > 7'd63) begin
            r = {s, 31'd0};
        end else begin
            q    = m >> sh;
            msk  = (64'd1 << sh) - 64'd1;
            rem  = m & msk;
            half = 64'd1 << (sh - 7'd1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            if (bexp >= 12'sd1) begin
                if (q[24]) begin
                    q    = q >> 1;
                    bexp = bexp + 12'sd1;
                end
                if (bexp >= 12'sd255) r = {s, InfBits[30:0]};
                else r = {s, bexp[7:0], q[22:0]};
            end else begin
                r = {s, q[30:0]};
            end
        end
        return r;
    endfunction

endpackage

/* rtl/matrix_vector_transform_4x4_core.sv */
// ============================================================================
// matrix_vector_transform_4x4_core
// Streams fp32 4-vectors through a 4x4 matrix held in configuration registers.
// ============================================================================
// One vector enters per cycle and one transformed vector leaves per cycle
// while the output is not stalled. A result passes through four multiplies
// per row in parallel (3 stages), one product register, then four chained
// adds per row (3 stages each), and the output register. The whole pipeline
// advances only while the output register is free or being taken, so a
// stall holds every stage in place.
// Matrix resets to identity; write it only while the pipeline is empty.
module matrix_vector_transform_4x4_core
    import mvt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [63:0]         cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [127:0]        s_tdata,   // in_x, in_y, in_z, in_w
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [127:0]        m_tdata    // out_x, out_y, out_z, out_w
);

    localparam int unsigned Lat = 16;

    // configuration registers
    logic [63:0] cfg_reg [NumRegs];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumRegs; i++) cfg_reg[i] <= ResetVals[i];
        end else if (cfg_we && cfg_addr < CfgAddrW'(NumRegs)) begin
            cfg_reg[cfg_addr[RegIdxW-1:0]] <= cfg_wdata;
        end
    end

    // pipeline advance
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [Lat-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Lat-2:0], s_tvalid};
    end

    // product delay lines so each add stage sees its product
    logic [31:0] prod [4][4];
    logic [31:0] vin  [4];
    logic [31:0] row_res [4];
    for (genvar c = 0; c < 4; c++) begin : g_v
        assign vin[c] = s_tdata[32*c +: 32];
    end

    // multiplies: each product runs through a delay line sized by its column so it meets its running sum
    for (genvar r = 0; r < 4; r++) begin : g_row
        logic [31:0] acc [5];
        assign acc[0] = 32'd0;
        for (genvar c = 0; c < 4; c++) begin : g_col
            logic [31:0] pm;
            logic [31:0] dly_reg [3*c+1];
            mvt_fmul u_mul (
                .aclk(aclk), .en(en),
                .a(cfg_reg[2*r + c/2][32*(c%2) +: 32]), .b(vin[c]), .p(pm)
            );
            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[0] <= pm;
                    for (int k = 1; k <= 3*c; k++) dly_reg[k] <= dly_reg[k-1];
                end
            end
            assign prod[r][c] = dly_reg[3*c];
            mvt_fadd u_add (
                .aclk(aclk), .en(en), .a(acc[c]), .b(prod[r][c]), .y(acc[c+1])
            );
        end
        assign row_res[r] = acc[4];
    end

    // output data register
    always_ff @(posedge aclk) begin
        if (en) m_tdata <= {row_res[3], row_res[2], row_res[1], row_res[0]};
    end

    // output register valid: last valid stage lines up with the row sums
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (en) m_tvalid <= vld_reg[Lat-1];
    end

    // no result without an earlier transaction
    a_valid_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vld_reg[Lat-1])) else $error("stray result");
    // stall holds result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("lost result");
    // ready follows output state
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");

endmodule

/* rtl/mvt_fmul.sv */
// ============================================================================
// mvt_fmul
// Three-stage fp32 multiplier: unpack/multiply, normalize, round.
// ============================================================================
module mvt_fmul
    import mvt_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);

    fcls_t ca, cb;
    logic [23:0] ma, mb;
    logic signed [11:0] ea, eb;

    assign ca = fclass(a);
    assign cb = fclass(b);
    assign ma = {(a[30:23] != 8'd0), a[22:0]};
    assign mb = {(b[30:23] != 8'd0), b[22:0]};
    assign ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
    assign eb = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;

    // stage 1: significand product and special result
    logic [47:0]        prod_reg;
    logic signed [11:0] e1_reg;
    logic               s1_reg, sp1_reg;
    logic [31:0]        spv1_reg;
    logic               sp1_next;
    logic [31:0]        spv1_next;
    logic               s;

    assign s = a[31] ^ b[31];

    always_comb begin
        sp1_next  = 1'b1;
        spv1_next = {s, 31'd0};
        if (ca.nan || cb.nan) spv1_next = QnanBits;
        else if (ca.inf || cb.inf)
            spv1_next = (ca.zero || cb.zero) ? QnanBits : {s, InfBits[30:0]};
        else if (!(ca.zero || cb.zero)) sp1_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= ma * mb;
            e1_reg   <= ea + eb;
            s1_reg   <= s;
            sp1_reg  <= sp1_next;
            spv1_reg <= spv1_next;
        end
    end

    // stage 2: normalize to bit 62
    logic [63:0]        m2_reg;
    logic signed [11:0] e2_reg;
    logic               s2_reg, sp2_reg;
    logic [31:0]        spv2_reg;
    logic [6:0]         lz;

    assign lz = lzc64({16'd0, prod_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_reg   <= {16'd0, prod_reg} << (lz - 7'd1);
            e2_reg   <= e1_reg - $signed({5'd0, lz}) + 12'sd1;
            s2_reg   <= s1_reg;
            sp2_reg  <= sp1_reg;
            spv2_reg <= spv1_reg;
        end
    end

    // stage 3: round
    always_ff @(posedge aclk) begin
        if (en) p <= sp2_reg ? spv2_reg : fround(s2_reg, e2_reg, m2_reg);
    end

endmodule

/* rtl/mvt_fadd.sv */
// ============================================================================
// mvt_fadd
// Three-stage fp32 adder: align, add and normalize, round.
// ============================================================================
module mvt_fadd
    import mvt_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    fcls_t ca, cb;
    assign ca = fclass(a);
    assign cb = fclass(b);

    logic [31:0] big, sml;
    logic        swap;
    assign swap = b[30:0] > a[30:0];
    assign big  = swap ? b : a;
    assign sml  = swap ? a : b;

    logic [7:0] eb_f, es_f;
    assign eb_f = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    assign es_f = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];

    // significands sit with 38 guard bits below the last fraction bit
    logic [7:0]  d;
    logic [63:0] mbig, msml, mal;
    logic        lost;
    assign d    = eb_f - es_f;
    assign mbig = {2'd0, (big[30:23] != 8'd0), big[22:0], 38'd0};
    assign msml = {2'd0, (sml[30:23] != 8'd0), sml[22:0], 38'd0};

    always_comb begin
        if (d >= 8'd63) begin
            mal  = 64'd1;
            lost = 1'b0;
        end else begin
            mal  = msml >> d[5:0];
            lost = ((msml & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0);
            mal[0] = mal[0] | lost;
        end
    end

    // special results
    logic        sp1_next;
    logic [31:0] spv1_next;
    always_comb begin
        sp1_next  = 1'b1;
        spv1_next = a;
        if (ca.nan || cb.nan) spv1_next = QnanBits;
        else if (ca.inf) spv1_next = (cb.inf && a[31] != b[31]) ? QnanBits : a;
        else if (cb.inf) spv1_next = b;
        else if (ca.zero && cb.zero) spv1_next = {a[31] & b[31], 31'd0};
        else if (ca.zero) spv1_next = b;
        else if (cb.zero) spv1_next = a;
        else sp1_next = 1'b0;
    end

    // stage 1: aligned operands
    logic [63:0] ma_reg, mb_reg;
    logic [7:0]  e1_reg;
    logic        sa_reg, sub_reg, sp1_reg;
    logic [31:0] spv1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= mbig;
            mb_reg   <= mal;
            e1_reg   <= eb_f;
            sa_reg   <= big[31];
            sub_reg  <= big[31] ^ sml[31];
            sp1_reg  <= sp1_next;
            spv1_reg <= spv1_next;
        end
    end

    // stage 2: add or subtract (magnitude order already set) and normalize
    logic [63:0] sum;
    logic [6:0]  lz;
    assign sum = sub_reg ? ma_reg - mb_reg : ma_reg + mb_reg;
    assign lz  = lzc64(sum);

    logic [63:0]        m2_reg;
    logic signed [11:0] e2_reg;
    logic               s2_reg, sp2_reg;
    logic [31:0]        spv2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_reg   <= sum << (lz - 7'd1);
            e2_reg   <= $signed({4'd0, e1_reg}) - 12'sd188 - $signed({5'd0, lz}) + 12'sd1;
            s2_reg   <= sa_reg;
            sp2_reg  <= sp1_reg || (sum == 64'd0);
            spv2_reg <= sp1_reg ? spv1_reg : 32'd0;
        end
    end

    // stage 3: round
    always_ff @(posedge aclk) begin
        if (en) y <= sp2_reg ? spv2_reg : fround(s2_reg, e2_reg, m2_reg);
    end

endmodule

/* test/tb_matrix_vector_transform_4x4_core.sv */
// ============================================================================
// tb_matrix_vector_transform_4x4_core
// Self-checking bench for the fp32 4x4 matrix-vector streaming core.
// ============================================================================
// Runs a series of matrices (identity from reset, zero, NaN-filled, huge, random
// mixes), streams vectors through each one, mostly with bursty input and random
// output stalls, and checks every result word against directed expectations or a bit-exact fp32 predictor.

module tb_matrix_vector_transform_4x4_core;
    import mvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ClkHalf     = 10;
    localparam int unsigned PipeLatency = 16;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned RandItems   = 1800;

    // register indexes
    localparam logic [CfgAddrW-1:0] Row0Left  = 4'd0;
    localparam logic [CfgAddrW-1:0] Row0Right = 4'd1;
    localparam logic [CfgAddrW-1:0] Row1Left  = 4'd2;
    localparam logic [CfgAddrW-1:0] Row1Right = 4'd3;
    localparam logic [CfgAddrW-1:0] Row2Left  = 4'd4;
    localparam logic [CfgAddrW-1:0] Row2Right = 4'd5;
    localparam logic [CfgAddrW-1:0] Row3Left  = 4'd6;
    localparam logic [CfgAddrW-1:0] Row3Right = 4'd7;

    localparam logic [31:0] FpOne    = 32'h3F80_0000;
    localparam logic [31:0] FpMax    = 32'h7F7F_FFFF;
    localparam logic [31:0] FpNegInf = 32'hFF80_0000;

    typedef struct {
        logic [127:0] vec;
        bit           known;
        logic [127:0] res;
    } vec_row_t;

    typedef struct {
        bit           known;
        logic [127:0] res;
    } typed_res_t;

    logic           aclk;
    logic           aresetn;
    logic           cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [63:0]    cfg_wdata;
    logic           s_tvalid;
    logic           s_tready;
    logic [127:0]   s_tdata;    // in_x, in_y, in_z, in_w
    logic           m_tvalid;
    logic           m_tready;
    logic [127:0]   m_tdata;    // out_x, out_y, out_z, out_w

    // bench copy of the matrix registers
    logic [63:0]    matrix_regs [NumRegs];

    logic [127:0]   result_q [$];
    typed_res_t     typed_q [$];
    vec_row_t       dir_rows [$];

    int unsigned    cycle_cnt;
    int unsigned    err_cnt;
    int unsigned    items_sent;
    int unsigned    results_seen;
    int unsigned    matrices_loaded;
    int unsigned    ready_pct;
    int unsigned    burst_left;
    bit             gaps_on;

    matrix_vector_transform_4x4_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #(ClkHalf) aclk = ~aclk;

    // ------------------------------------------------------------------
    // fp32 arithmetic, round to nearest even after every operation
    // ------------------------------------------------------------------

    function automatic bit fp_is_nan(input logic [31:0] x);
        return x[30:0] > 31'h7F80_0000;
    endfunction

    function automatic bit fp_is_inf(input logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic bit fp_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // significand with hidden bit, value = sig * 2^expo
    function automatic logic [63:0] fp_sig(input logic [31:0] x, output int expo);
        if (x[30:23] == 8'd0) begin
            expo = -149;
            return {41'd0, x[22:0]};
        end
        expo = int'(x[30:23]) - 150;
        return {40'd0, 1'b1, x[22:0]};
    endfunction

    function automatic logic [31:0] fp_round(input logic sgn, input int expo,
                                             input logic [63:0] mant);
        int          bexp;
        int          sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        while (!mant[62]) begin
            mant = mant << 1;
            expo--;
        end
        bexp = expo + 189;
        sh   = (bexp >= 1) ? 39 : 40 - bexp;
        if (sh > 63) return {sgn, 31'd0};
        q    = mant >> sh;
        rem  = mant & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        if (bexp >= 1) begin
            if (q[24]) begin
                q = q >> 1;
                bexp++;
            end
            if (bexp >= 255) return {sgn, 31'h7F80_0000};
            return {sgn, 8'(bexp), q[22:0]};
        end
        return {sgn, q[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        int          ea;
        int          eb;
        logic [63:0] ma;
        logic [63:0] mb;
        sgn = a[31] ^ b[31];
        if (fp_is_nan(a) || fp_is_nan(b)) return QnanBits;
        if (fp_is_inf(a) || fp_is_inf(b)) begin
            if (fp_is_zero(a) || fp_is_zero(b)) return QnanBits;
            return {sgn, 31'h7F80_0000};
        end
        if (fp_is_zero(a) || fp_is_zero(b)) return {sgn, 31'd0};
        ma = fp_sig(a, ea);
        mb = fp_sig(b, eb);
        return fp_round(sgn, ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        sa;
        logic        sb;
        logic        sgn;
        int          ea;
        int          eb;
        int          d;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] sum;
        logic [63:0] tm;
        int          te;
        logic        ts;
        sa = a[31];
        sb = b[31];
        if (fp_is_nan(a) || fp_is_nan(b)) return QnanBits;
        if (fp_is_inf(a)) begin
            if (fp_is_inf(b) && sa != sb) return QnanBits;
            return a;
        end
        if (fp_is_inf(b)) return b;
        if (fp_is_zero(a) && fp_is_zero(b)) return {sa & sb, 31'd0};
        if (fp_is_zero(a)) return b;
        if (fp_is_zero(b)) return a;
        ma = fp_sig(a, ea) << 38;
        mb = fp_sig(b, eb) << 38;
        // larger exponent first
        if (eb > ea) begin
            tm = ma; ma = mb; mb = tm;
            te = ea; ea = eb; eb = te;
            ts = sa; sa = sb; sb = ts;
        end
        d = ea - eb;
        if (d >= 63) begin
            mb = (mb != 64'd0) ? 64'd1 : 64'd0;
        end else if (d > 0) begin
            tm = mb & ((64'd1 << d) - 64'd1);
            mb = mb >> d;
            if (tm != 64'd0) mb[0] = 1'b1;
        end
        if (sa == sb) begin
            sum = ma + mb;
            sgn = sa;
        end else if (ma >= mb) begin
            sum = ma - mb;
            sgn = sa;
        end else begin
            sum = mb - ma;
            sgn = sb;
        end
        if (sum == 64'd0) return 32'd0;
        return fp_round(sgn, ea - 38, sum);
    endfunction

    // matrix times vector, each row summed from +0 in column order
    function automatic logic [127:0] transform_vec(input logic [127:0] vec);
        logic [127:0] res;
        logic [31:0]  acc;
        logic [63:0]  pair;
        logic [31:0]  m;
        for (int r = 0; r < 4; r++) begin
            acc = 32'd0;
            for (int c = 0; c < 4; c++) begin
                pair = matrix_regs[2 * r + c / 2];
                m    = (c % 2 == 1) ? pair[63:32] : pair[31:0];
                acc  = fp_add(acc, fp_mul(m, vec[32 * c +: 32]));
            end
            res[32 * r +: 32] = acc;
        end
        return res;
    endfunction

    function automatic logic [127:0] pack_vec(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [31:0] w);
        return {w, z, y, x};
    endfunction

    // random fp32 pattern; tame values keep matrices mostly in a useful range
    function automatic logic [31:0] rand_fp(input bit tame);
        logic [31:0] v;
        int unsigned pick;
        v    = $urandom;
        pick = tame ? (($urandom_range(0, 9) == 0) ? $urandom_range(0, 4)
                                                   : 5) : $urandom_range(0, 11);
        case (pick)
            0: v[30:0] = 31'd0;
            1: v[30:0] = 31'h7F80_0000;
            2: v[30:23] = 8'hFF;
            3: v[30:23] = 8'h00;
            4: v[30:0] = ($urandom_range(0, 1) == 1) ? FpMax[30:0] : 31'h0080_0000;
            5, 6, 7: v[30:23] = 8'($urandom_range(110, 144));
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx < NumRegs) matrix_regs[idx] = val;
    endtask

    // writes all eight registers plus a stray write to an unused index
    task automatic load_matrix(input logic [63:0] vals [NumRegs]);
        write_reg(Row0Left,  vals[0]);
        write_reg(Row0Right, vals[1]);
        write_reg(Row1Left,  vals[2]);
        write_reg(Row1Right, vals[3]);
        write_reg(Row2Left,  vals[4]);
        write_reg(Row2Right, vals[5]);
        write_reg(Row3Left,  vals[6]);
        write_reg(Row3Right, vals[7]);
        write_reg(CfgAddrW'($urandom_range(NumRegs, 15)), {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge aclk);
        matrices_loaded++;
    endtask

    task automatic drain_pipe();
        while (result_q.size() != 0 || typed_q.size() != 0) @(posedge aclk);
        repeat (PipeLatency + 6) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // input side: bursts with random gaps
    // ------------------------------------------------------------------

    task automatic send_vec(input logic [127:0] vec, input bit known, input logic [127:0] res);
        int unsigned gap;
        typed_q.push_back('{known: known, res: res});
        s_tdata  <= vec;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random(input int unsigned count, input bit tame);
        repeat (count) begin
            send_vec(pack_vec(rand_fp(tame), rand_fp(tame), rand_fp(tame), rand_fp(tame)),
                     1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, expected results from input transactions
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge aclk) begin
        typed_res_t   t;
        logic [127:0] want;
        if (aresetn && s_tvalid && s_tready) begin
            t = typed_q.pop_front();
            result_q.push_back(t.known ? t.res : transform_vec(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result transaction %h", m_tdata);
            end else begin
                want = result_q.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_tdata[32 * f +: 32] !== want[32 * f +: 32]) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch field %0d: expected %h actual %h",
                                     f, want[32 * f +: 32], m_tdata[32 * f +: 32]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        logic [63:0] vals [NumRegs];
        int unsigned per_phase;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cycle_cnt = 0;
        err_cnt   = 0;
        items_sent      = 0;
        results_seen    = 0;
        matrices_loaded = 0;
        burst_left = 0;
        gaps_on    = 1'b1;
        ready_pct  = 70;
        foreach (matrix_regs[i]) matrix_regs[i] = ResetVals[i];

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed vectors through the identity matrix left by reset
        dir_rows.push_back('{pack_vec(FpOne, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000), 1,
                             pack_vec(FpOne, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000)});
        dir_rows.push_back('{'0, 1, '0});
        // negative zeros sum to +0
        dir_rows.push_back('{{4{32'h8000_0000}}, 1, '0});
        dir_rows.push_back('{pack_vec(32'h7FFF_FFFF, FpOne, FpOne, FpOne), 1, {4{QnanBits}}});
        dir_rows.push_back('{{4{32'hFFFF_FFFF}}, 1, {4{QnanBits}}});
        // infinity times zero gives NaN in the other rows
        dir_rows.push_back('{pack_vec(InfBits, FpOne, 32'h4000_0000, FpOne), 1,
                             pack_vec(InfBits, QnanBits, QnanBits, QnanBits)});
        dir_rows.push_back('{pack_vec(FpOne, FpOne, FpOne, FpNegInf), 1,
                             pack_vec(QnanBits, QnanBits, QnanBits, FpNegInf)});
        dir_rows.push_back('{{4{FpMax}}, 1, {4{FpMax}}});
        dir_rows.push_back('{{4{32'h0000_0001}}, 1, {4{32'h0000_0001}}});
        dir_rows.push_back('{{4{32'h8000_0001}}, 1, {4{32'h8000_0001}}});
        dir_rows.push_back('{{4{32'h0080_0000}}, 1, {4{32'h0080_0000}}});
        dir_rows.push_back('{{4{32'h807F_FFFF}}, 0, '0});
        dir_rows.push_back('{{4{32'h5555_5555}}, 0, '0});
        dir_rows.push_back('{{4{32'hAAAA_AAAA}}, 0, '0});
        dir_rows.push_back('{pack_vec(32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0000),
                             0, '0});
        foreach (dir_rows[i]) send_vec(dir_rows[i].vec, dir_rows[i].known, dir_rows[i].res);
        s_tvalid <= 1'b0;
        drain_pipe();

        // zero matrix
        foreach (vals[i]) vals[i] = 64'd0;
        load_matrix(vals);
        send_random(60, 1'b0);
        drain_pipe();

        // every entry a NaN with all bits set
        foreach (vals[i]) vals[i] = '1;
        load_matrix(vals);
        send_random(30, 1'b0);
        drain_pipe();

        // largest finite entries push rows into overflow
        foreach (vals[i]) vals[i] = {FpMax, FpMax};
        vals[3] = {FpMax | 32'h8000_0000, FpMax};
        load_matrix(vals);
        send_random(80, 1'b1);
        drain_pipe();

        // cancelling row: row 0's right pair holds the negated entries of its left pair
        foreach (vals[i]) vals[i] = {rand_fp(1'b1), rand_fp(1'b1)};
        vals[1] = {vals[0][63:32] ^ 32'h8000_0000, vals[0][31:0] ^ 32'h8000_0000};
        load_matrix(vals);
        send_random(80, 1'b1);
        drain_pipe();

        // random matrices, random stall and gap behavior per phase
        per_phase = 175;
        for (int p = 0; p < 9; p++) begin
            foreach (vals[i]) vals[i] = {rand_fp(1'b1), rand_fp(1'b1)};
            load_matrix(vals);
            gaps_on   = (p % 3 != 0);
            ready_pct = (p % 3 == 0) ? 100 : $urandom_range(25, 90);
            send_random(per_phase, (p % 2 == 0));
            drain_pipe();
        end

        $display("%0d vectors sent over %0d matrix loads, %0d results checked",
                 items_sent, matrices_loaded, results_seen);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
